/* rtl/slotted_page_directory_macros.svh */
// Assertion macros for the slotted page directory checker.
// Depends on nothing; included by the checker file.
`ifndef SLOTTED_PAGE_DIRECTORY_MACROS_SVH
`define SLOTTED_PAGE_DIRECTORY_MACROS_SVH
// same-cycle implication
`define SPD_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spd assertion failed");
// next-cycle implication
`define SPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spd assertion failed");
`endif

/* rtl/spd_pkg.sv */
// Package for the slotted page directory: widths, codes, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package spd_pkg;
   localparam int OFF_W = 13;
   localparam int LEN_W = 13;
   localparam int IDX_W = 6;
   localparam int CNTF_W = 7;
   localparam int REQ_W = 3;
   localparam int HDR_W = 8;
   localparam int STAT_W = 2;
   localparam int IN_DATA_W = 72;
   localparam int OUT_DATA_W = 48;
   localparam int DEF_PAGE_BYTES = 4096;
   localparam int DEF_MAX_SLOTS = 64;
   localparam logic [HDR_W-1:0] HDR_RESET = 8'd24;
   localparam logic [OFF_W-1:0] OFF_MAX = 13'h1FFF;

   localparam logic [REQ_W-1:0] REQ_INIT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
   localparam logic [REQ_W-1:0] REQ_WALK = 3'd2;
   localparam logic [REQ_W-1:0] REQ_LOAD_HDR = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LOAD_SLOT = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_LAYOUT = 2'd2;
   localparam logic [STAT_W-1:0] ST_DIR_FULL = 2'd3;

   typedef struct packed {
      logic latch;
      logic single_do;
      logic scan_start;
      logic scan_step;
      logic take_best;
      logic advance;
      logic emit_rec;
   } cmd_type;

   typedef struct packed {
      logic valid_op;
      logic is_walk;
      logic empty;
      logic scan_done;
      logic cur_has;
      logic need_succ;
      logic walk_err;
      logic out_free;
   } status_type;
endpackage

/* rtl/spd_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module spd_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

/* rtl/spd_ctrl.sv */
// Controller for the slotted page directory: sequences requests and walk scans.
// Depends on spd_pkg.
`timescale 1ns / 1ps
module spd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  spd_pkg::status_type stat,
   output spd_pkg::cmd_type    cmd
);
   import spd_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SINGLE = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_ADV    = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.valid_op) begin
               state_in = S_IDLE;
            end else if (stat.is_walk && !stat.empty) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_SINGLE;
            end
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.single_do = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.cur_has) begin
               cmd.take_best = 1'b1;
               state_in = S_ADV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_ADV: begin
            if (stat.need_succ) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_rec = 1'b1;
               if (stat.walk_err || !stat.need_succ) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in = S_ADV;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

/* rtl/spd_datapath.sv */
// Datapath for the slotted page directory: page header state, slot RAM,
// walk scan compare and the result register. Depends on spd_pkg and spd_ram.
`timescale 1ns / 1ps
module spd_datapath #(
   parameter int PAGE_BYTES = spd_pkg::DEF_PAGE_BYTES,
   parameter int MAX_SLOTS = spd_pkg::DEF_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [spd_pkg::REQ_W-1:0]       req_tuser,
   input  logic [spd_pkg::IN_DATA_W-1:0]   req_tdata,
   input  logic                            csr_we,
   input  logic [spd_pkg::HDR_W-1:0]       csr_wdata,
   input  spd_pkg::cmd_type                cmd,
   output spd_pkg::status_type             stat,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spd_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import spd_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
   localparam logic [OFF_W:0] PAGE_W = (OFF_W+1)'(PAGE_BYTES);

   // latched request
   logic [REQ_W-1:0]  kind_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [CNTF_W-1:0] lcount_ff;
   logic [OFF_W-1:0]  lstart_ff, lsize_ff, sval_ff;
   logic [IDX_W-1:0]  spos_ff;

   // page state
   logic [HDR_W-1:0]  hdr_ff;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [OFF_W-1:0]  fstart_ff, fstart_in, fbytes_ff, fbytes_in;

   // walk scan
   logic [CNT_W-1:0]  k_ff, issue_ff, rd_i_ff, best_i_ff, cur_i_ff;
   logic              rd_v_ff, best_found_ff, cur_has_ff;
   logic [OFF_W-1:0]  best_v_ff, cur_v_ff;

   // result register
   logic                  ovalid_ff, olast_ff;
   logic [OUT_DATA_W-1:0] odata_ff;

   // RAM port
   logic              ram_we;
   logic [SLOT_W-1:0] ram_addr;
   logic [OFF_W-1:0]  ram_wdata, ram_rdata;

   logic              is_append, is_lslot, full, nospace, slot_ok, out_free;
   logic [OFF_W:0]    need, end_sum, region, nxt_diff;
   logic [OFF_W-1:0]  end_sat, nxt;
   logic [CNT_W-1:0]  rd_pos, cnt_sat, num_inc;
   logic              cand_gt, cand_lt;
   logic [STAT_W-1:0] o_status;
   logic              o_valid, o_last;
   logic [IDX_W-1:0]  o_idx;
   logic [OFF_W-1:0]  o_off, o_bytes;

   spd_ram #(.WIDTH(OFF_W), .DEPTH(MAX_SLOTS), .ADDR_W(SLOT_W)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign is_append = (kind_ff == REQ_APPEND);
   assign is_lslot = (kind_ff == REQ_LOAD_SLOT);
   assign full = (num_ff >= MAX_CNT);
   assign need = {1'b0, len_ff} + (OFF_W+1)'(2);
   assign nospace = ({1'b0, fbytes_ff} < need);
   assign slot_ok = ({1'b0, spos_ff} < (IDX_W+1)'(MAX_SLOTS));
   assign num_inc = num_ff + CNT_W'(1);
   assign end_sum = {1'b0, fstart_ff} + {1'b0, len_ff};
   assign end_sat = end_sum[OFF_W] ? OFF_MAX : end_sum[OFF_W-1:0];
   assign region = PAGE_W - (OFF_W+1)'({num_inc, 1'b0});
   assign cnt_sat = (lcount_ff > CNTF_W'(MAX_SLOTS)) ? MAX_CNT : CNT_W'(lcount_ff);
   assign out_free = !ovalid_ff || rsp_tready;
   assign rd_pos = num_ff - CNT_W'(1) - issue_ff;

   always_comb begin
      ram_we = 1'b0;
      ram_wdata = fstart_ff;
      ram_addr = rd_pos[SLOT_W-1:0];
      if (cmd.single_do && is_append && !full && !nospace) begin
         ram_we = 1'b1;
         ram_addr = num_ff[SLOT_W-1:0];
      end else if (cmd.single_do && is_lslot && slot_ok) begin
         ram_we = 1'b1;
         ram_wdata = sval_ff;
         ram_addr = spos_ff[SLOT_W-1:0];
      end
   end

   // next state of the page header
   always_comb begin
      num_in = num_ff;
      fstart_in = fstart_ff;
      fbytes_in = fbytes_ff;
      case (kind_ff)
         REQ_INIT: begin
            num_in = '0;
            fstart_in = OFF_W'(hdr_ff);
            fbytes_in = OFF_W'(PAGE_W - (OFF_W+1)'(hdr_ff));
         end
         REQ_APPEND: begin
            if (!full && !nospace) begin
               num_in = num_inc;
               fstart_in = end_sat;
               fbytes_in = (region > {1'b0, end_sat}) ?
                           OFF_W'(region - {1'b0, end_sat}) : '0;
            end
         end
         REQ_LOAD_HDR: begin
            num_in = cnt_sat;
            fstart_in = lstart_ff;
            fbytes_in = lsize_ff;
         end
         default: begin
         end
      endcase
   end

   // walk: key order is (offset, walk index)
   assign cand_gt = !cur_has_ff || (ram_rdata > cur_v_ff) ||
                    ((ram_rdata == cur_v_ff) && (rd_i_ff > cur_i_ff));
   assign cand_lt = !best_found_ff || (ram_rdata < best_v_ff);
   assign nxt = stat.need_succ ? best_v_ff : fstart_ff;
   assign nxt_diff = {1'b0, nxt} - {1'b0, cur_v_ff};

   assign stat.valid_op = (kind_ff <= REQ_LOAD_SLOT);
   assign stat.is_walk = (kind_ff == REQ_WALK);
   assign stat.empty = (num_ff == '0);
   assign stat.scan_done = rd_v_ff && (rd_i_ff == num_ff - CNT_W'(1));
   assign stat.cur_has = cur_has_ff;
   assign stat.need_succ = ({1'b0, k_ff} + (CNT_W+1)'(1)) < {1'b0, num_ff};
   assign stat.walk_err = (nxt < cur_v_ff) || (nxt > fstart_ff);
   assign stat.out_free = out_free;

   // result fields
   always_comb begin
      o_status = ST_OK;
      o_valid = 1'b0;
      o_idx = '0;
      o_off = '0;
      o_bytes = '0;
      o_last = 1'b1;
      if (cmd.emit_rec) begin
         if (stat.walk_err) begin
            o_status = ST_LAYOUT;
         end else begin
            o_valid = 1'b1;
            o_idx = IDX_W'(cur_i_ff);
            o_off = cur_v_ff;
            o_bytes = nxt_diff[OFF_W-1:0];
            o_last = !stat.need_succ;
         end
      end else if (is_append) begin
         if (full) begin
            o_status = ST_DIR_FULL;
         end else if (nospace) begin
            o_status = ST_NO_SPACE;
         end else begin
            o_valid = 1'b1;
            o_off = fstart_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_tuser;
         len_ff <= req_tdata[12:0];
         lcount_ff <= req_tdata[19:13];
         lstart_ff <= req_tdata[32:20];
         lsize_ff <= req_tdata[45:33];
         spos_ff <= req_tdata[51:46];
         sval_ff <= req_tdata[64:52];
      end
      if (cmd.single_do || cmd.emit_rec) begin
         odata_ff <= {6'd0, CNTF_W'(cmd.single_do ? num_in : num_ff), o_bytes, o_off,
                      o_idx, o_valid, o_status};
         olast_ff <= o_last;
      end
      // scan datapath
      if (cmd.scan_start) begin
         issue_ff <= '0;
         best_found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (issue_ff < num_ff) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         rd_i_ff <= issue_ff;
         if (rd_v_ff && cand_gt && cand_lt) begin
            best_found_ff <= 1'b1;
            best_v_ff <= ram_rdata;
            best_i_ff <= rd_i_ff;
         end
      end
      if (cmd.take_best || cmd.advance) begin
         cur_v_ff <= best_v_ff;
         cur_i_ff <= best_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= HDR_RESET;
         num_ff <= '0;
         fstart_ff <= OFF_W'(HDR_RESET);
         fbytes_ff <= OFF_W'(PAGE_W - (OFF_W+1)'(HDR_RESET));
         ovalid_ff <= 1'b0;
         rd_v_ff <= 1'b0;
         cur_has_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         if (csr_we) begin
            hdr_ff <= csr_wdata;
         end
         if (cmd.single_do) begin
            num_ff <= num_in;
            fstart_ff <= fstart_in;
            fbytes_ff <= fbytes_in;
         end
         if (cmd.single_do || cmd.emit_rec) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         rd_v_ff <= cmd.scan_step && !cmd.scan_start && (issue_ff < num_ff);
         if (cmd.latch) begin
            cur_has_ff <= 1'b0;
            k_ff <= '0;
         end else if (cmd.take_best) begin
            cur_has_ff <= 1'b1;
         end else if (cmd.advance) begin
            k_ff <= k_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = odata_ff;
   assign rsp_tlast = olast_ff;
endmodule

/* rtl/slotted_page_directory.sv */
// Slotted page directory: init/append/load/walk over a page's slot table.
// Init, append, loads and an empty walk pass decode and a single-step state, which
// waits for the result register to be free; a new request is taken only back in idle.
// A walk of n records runs n scans on the one slot RAM port, one before each record.
// Reset (synchronous, active high): empty page, header_bytes = 24, no result pending;
// slot RAM content is not cleared.
`timescale 1ns / 1ps
module slotted_page_directory #(
   parameter int PAGE_BYTES = spd_pkg::DEF_PAGE_BYTES,
   parameter int MAX_SLOTS = spd_pkg::DEF_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tuser: req_type[2:0]
   input  logic [spd_pkg::REQ_W-1:0]       req_tuser,
   // req_tdata: record_length[12:0], load_count[19:13], load_free_start[32:20],
   // load_free_size[45:33], slot_position[51:46], slot_value[64:52], zero pad
   input  logic [spd_pkg::IN_DATA_W-1:0]   req_tdata,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: status[1:0], record_valid[2], directory_index[8:3],
   // record_offset[21:9], record_bytes[34:22], record_count[41:35], zero pad
   output logic [spd_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // header_bytes register
   input  logic                            csr_we,
   input  logic [spd_pkg::HDR_W-1:0]       csr_wdata
);
   import spd_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // sequencer: request intake, scan loop, emit handshaking
   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // page state, slot RAM, min-search compare, result register
   spd_datapath #(.PAGE_BYTES(PAGE_BYTES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

/* rtl/spd_checker.sv */
// Port-level checker for slotted_page_directory, bound to the top level.
// Depends on spd_pkg and slotted_page_directory_macros.svh.
`timescale 1ns / 1ps
`include "slotted_page_directory_macros.svh"
module spd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [spd_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);
   import spd_pkg::*;

   // stalled response holds its payload
   `SPD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // nothing pending right after reset
   `SPD_ASSERT(a_rst_idle, clock, 1'b0, $past(reset) && !reset, !rsp_tvalid)
   // mid-walk, intake stays closed
   `SPD_ASSERT(a_walk_busy, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)
   // a non-final result is always a good record
   `SPD_ASSERT(a_mid_rec, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[2] && (rsp_tdata[1:0] == ST_OK))
endmodule

bind slotted_page_directory spd_checker u_spd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
